// ===== rtl/s128_pkg.sv =====
// ----------------------------------------------------------------------------
// s128_pkg: shared types and constants for the 128-bit signed ALU.
// Holds the operation codes and the command and status records that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package s128_pkg;

    localparam int unsigned OpWidth  = 128;
    localparam int unsigned CntWidth = 7;

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0,
        ACT_SUB = 4'd1,
        ACT_MUL = 4'd2,
        ACT_DIV = 4'd3,
        ACT_AND = 4'd4,
        ACT_OR  = 4'd5,
        ACT_XOR = 4'd6,
        ACT_NOT = 4'd7,
        ACT_SHL = 4'd8,
        ACT_SAR = 4'd9,
        ACT_ROL = 4'd10,
        ACT_ROR = 4'd11
    } t_action;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture operands and set up iteration
        logic step;      // one multiply or divide iteration
        logic fix;       // apply the sign to the iterated result
        logic simple;    // compute a non-iterative operation
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic iterative; // loaded action needs the iterative unit
        logic last_step; // current iteration is the final one
    } t_dp_stat;

endpackage

// ===== rtl/s128_datapath.sv =====
// ----------------------------------------------------------------------------
// s128_datapath: operand registers, shift-and-add multiplier, restoring
// divider and non-iterative logic for the 128-bit signed ALU.
// One multiply or divide iteration happens per step command.
// ----------------------------------------------------------------------------
module s128_datapath
    import s128_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [3:0]           i_action,
    input  logic [OpWidth-1:0]   i_a,
    input  logic [OpWidth-1:0]   i_b,
    input  logic [CntWidth-1:0]  i_shamt,
    output t_dp_stat             o_stat,
    output logic [OpWidth+3:0]   o_result   // result, zero, neg, lt, eq
);

    logic [3:0]          r_act;
    logic [OpWidth-1:0]  r_a, r_b, r_mag_b, r_acc, r_rem, r_num, r_res;
    logic                r_flip, r_lt, r_eq, r_bzero;
    logic [CntWidth-1:0] r_shamt, r_cnt;

    logic [OpWidth-1:0]  w_ma, w_mb, n_res, w_sar;
    logic [OpWidth:0]    w_trial, w_rsh;
    logic                w_sa, w_sb;

    assign w_sa = i_a[OpWidth-1];
    assign w_sb = i_b[OpWidth-1];
    assign w_ma = w_sa ? (~i_a + 1'b1) : i_a;
    assign w_mb = w_sb ? (~i_b + 1'b1) : i_b;

    // Divider trial subtraction on the shifted remainder.
    assign w_rsh   = {r_rem, r_num[OpWidth-1]};
    assign w_trial = w_rsh - {1'b0, r_mag_b};

    assign w_sar = $signed(r_a) >>> r_shamt;

    // Non-iterative operations.
    always_comb begin
        unique case (r_act)
            ACT_ADD: n_res = r_a + r_b;
            ACT_SUB: n_res = r_a - r_b;
            ACT_AND: n_res = r_a & r_b;
            ACT_OR:  n_res = r_a | r_b;
            ACT_XOR: n_res = r_a ^ r_b;
            ACT_NOT: n_res = ~r_a;
            ACT_SHL: n_res = r_a << r_shamt;
            ACT_SAR: n_res = w_sar;
            ACT_ROL: n_res = {r_a[OpWidth-2:0], r_a[OpWidth-1]};
            ACT_ROR: n_res = {r_a[0], r_a[OpWidth-1:1]};
            default: n_res = '0;
        endcase
    end

    assign o_stat.iterative = (r_act == ACT_MUL) || (r_act == ACT_DIV);
    assign o_stat.last_step = (r_cnt == '1);

    // Operand capture, iteration and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_a     <= i_a;
            r_b     <= i_b;
            r_shamt <= i_shamt;
            r_mag_b <= w_mb;
            r_num   <= w_ma;
            r_acc   <= '0;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_flip  <= w_sa ^ w_sb;
            r_bzero <= (i_b == '0);
            r_eq    <= (i_a == i_b);
            r_lt    <= (w_sa != w_sb) ? w_sa : (i_a < i_b);
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_act == ACT_MUL) begin
                // Multiplicand in r_num shifts left, multiplier in r_mag_b right.
                if (r_mag_b[0]) r_acc <= r_acc + r_num;
                r_num   <= r_num << 1;
                r_mag_b <= r_mag_b >> 1;
            end else begin
                r_num <= r_num << 1;
                if (!w_trial[OpWidth]) begin
                    r_rem <= w_trial[OpWidth-1:0];
                    r_acc <= {r_acc[OpWidth-2:0], 1'b1};
                end else begin
                    r_rem <= w_rsh[OpWidth-1:0];
                    r_acc <= {r_acc[OpWidth-2:0], 1'b0};
                end
            end
        end else if (i_cmd.fix) begin
            if (r_act == ACT_DIV && r_bzero) r_res <= '0;
            else r_res <= r_flip ? (~r_acc + 1'b1) : r_acc;
        end else if (i_cmd.simple) begin
            r_res <= n_res;
        end
    end

    assign o_result = {r_res, (r_res == '0), r_res[OpWidth-1], r_lt, r_eq};

`ifndef NO_ASSERTIONS
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd)) else $error("datapath got several commands at once");
    a_step_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> o_stat.iterative) else $error("step on a simple action");
    a_cnt_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> r_cnt == $past(r_cnt) + 1'b1) else $error("count slip");
`endif

endmodule

// ===== rtl/s128_ctrl.sv =====
// ----------------------------------------------------------------------------
// s128_ctrl: controller for the 128-bit signed ALU.
// Sequences load, iteration, sign fix and result hand-off.
// ----------------------------------------------------------------------------
module s128_ctrl
    import s128_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_STEP, S_FIX, S_SIMPLE, S_OUT} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // The input is open only while idle; a new item waits until the result has left.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = i_stat.iterative ? S_STEP : S_SIMPLE;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_stat.last_step) n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix   = 1'b1;
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_SIMPLE: begin
                o_cmd.simple = 1'b1;
                n_state      = S_OUT;
                n_out_valid  = 1'b1;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid == (r_state == S_OUT)) else $error("valid out of step");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("accept while result pending");
    a_fix_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fix |=> o_out_valid) else $error("fix not followed by result");
`endif

endmodule

// ===== rtl/signed_128bit_alu_mul_div.sv =====
// ----------------------------------------------------------------------------
// signed_128bit_alu_mul_div: 128-bit signed ALU with iterative mul and div.
// Simple actions pass through the decode and compute states to the result;
// multiply and divide run 128 iterations of the shared shift/add unit.
// Throughput: one item at a time; next accept after the result is taken.
// Reset (synchronous, active low) clears the controller; no result pends.
// ----------------------------------------------------------------------------
module signed_128bit_alu_mul_div
    import s128_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[3:0], a_high[67:4], a_low[131:68], b_high[195:132],
    // b_low[259:196], shift_amount[266:260], zero fill to 272
    input  logic [271:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_high[63:0], result_low[127:64], result_zero[128],
    // result_negative[129], a_less_than_b[130], a_equal_b[131], zeros to 136
    output logic [135:0] m_axis_tdata
);

    t_dp_cmd             w_cmd;
    t_dp_stat            w_stat;
    logic [OpWidth+3:0]  w_res;

    s128_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    s128_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_action (s_axis_tdata[3:0]),
        .i_a      ({s_axis_tdata[67:4], s_axis_tdata[131:68]}),
        .i_b      ({s_axis_tdata[195:132], s_axis_tdata[259:196]}),
        .i_shamt  (s_axis_tdata[266:260]),
        .o_stat   (w_stat),
        .o_result (w_res)
    );

    assign m_axis_tdata = {4'd0, w_res[0], w_res[1], w_res[2], w_res[3],
                           w_res[67:4], w_res[131:68]};

endmodule
